/* sv/daily_light_schedule_interpolator_top_defines.svh */
// assertion macros for the daily light schedule interpolator
// used by the top level, expects clk and arst_n in scope
`ifndef DAILY_LIGHT_SCHEDULE_INTERPOLATOR_TOP_DEFINES_SVH
`define DAILY_LIGHT_SCHEDULE_INTERPOLATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define DLSI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DLSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DLSI_ASSERT(lbl, prop, msg)
`define DLSI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/dlsi_pkg.sv */
// shared types and constants for the daily light schedule interpolator
// no dependencies
`default_nettype none
package dlsi_pkg;
	localparam int MAX_POINTS = 16;
	localparam int IDX_W = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int MIN_W = 11;
	localparam int LVL_W = 8;
	localparam int TOD_W = 17;
	localparam int SEC_W = 17;
	localparam int TD_W = 18;
	localparam int MUL_W = 27;
	localparam int NUM_W = 29;
	localparam int DIV_W = 56;
	localparam int QUO_W = 26;
	localparam int CNT_W = 5;
	localparam int DAY_SECONDS = 24 * 60 * 60;
	localparam int FULL_LEVEL = 255;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_EVAL = 2'd1;
	localparam logic [1:0] FUNC_REWIND = 2'd2;

	localparam logic REG_FADE = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef struct packed {
		logic [MIN_W-1:0] minutes;
		logic [LVL_W-1:0] level;
	} point_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [SEC_W-1:0] min_to_sec(input logic [MIN_W-1:0] m);
		logic [SEC_W-1:0] mx;
		mx = SEC_W'(m);
		return (mx << 6) - (mx << 2);
	endfunction
endpackage
`default_nettype wire

/* sv/dlsi_divider.sv */
// compare and subtract divider, one quotient bit per cycle
// saturating 8 bit quotient, or low 8 bits of the full quotient in wrap mode
// depends on dlsi_pkg
`default_nettype none
module dlsi_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       wrap,
	input  wire logic [dlsi_pkg::DIV_W-1:0] dividend,
	input  wire logic [dlsi_pkg::DIV_W-1:0] divisor,
	output logic      [dlsi_pkg::LVL_W-1:0] quotient,
	output dlsi_pkg::div_stat_t             stat
);
	import dlsi_pkg::*;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_STEP
	} dv_state_t;

	localparam int K_W = $clog2(QUO_W);
	localparam int B_W = $clog2(LVL_W);

	dv_state_t            state_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     den_q;
	logic [LVL_W-1:0]     q_q;
	logic [K_W-1:0]       k_q;
	logic                 wrap_q;
	logic                 done_q;
	logic [DIV_W-1:0]     shifted;
	logic [DIV_W-1:0]     sat_lim;

	assign shifted = den_q << k_q;
	assign sat_lim = den_q << LVL_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			rem_q <= '0;
			den_q <= '0;
			q_q <= '0;
			k_q <= '0;
			wrap_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DV_IDLE: begin
					if (start) begin
						rem_q <= dividend;
						den_q <= divisor;
						wrap_q <= wrap;
						q_q <= '0;
						state_q <= DV_CHECK;
					end
				end
				DV_CHECK: begin
					if (!wrap_q && (rem_q >= sat_lim)) begin
						q_q <= LVL_W'(FULL_LEVEL);
						done_q <= 1'b1;
						state_q <= DV_IDLE;
					end else begin
						k_q <= wrap_q ? K_W'(QUO_W - 1) : K_W'(LVL_W - 1);
						state_q <= DV_STEP;
					end
				end
				DV_STEP: begin
					if (rem_q >= shifted) begin
						rem_q <= rem_q - shifted;
						if (k_q < K_W'(LVL_W))
							q_q[k_q[B_W-1:0]] <= 1'b1;
					end
					if (k_q == '0) begin
						done_q <= 1'b1;
						state_q <= DV_IDLE;
					end else begin
						k_q <= k_q - K_W'(1);
					end
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	assign quotient = q_q;
	assign stat.busy = (state_q != DV_IDLE);
	assign stat.done = done_q;
endmodule
`default_nettype wire

/* sv/daily_light_schedule_interpolator_top.sv */
// daily light schedule interpolator, top level with sequencer and point table
// depends on dlsi_pkg, dlsi_divider and the assertion macro header
//
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       tuser: func; tdata: index, minutes, level, time
// m_*       out  m_tvalid / m_tready       tdata: light_value
// apb       in   psel & penable & pwrite   fade_mode at 0x0, point_count at 0x4
//
// a write or an ignored code keeps the sequencer idle, a rewind goes through ST_REWIND first
// an evaluate keeps s_tready low longer the more the cursor moves, longer still when the
// count is above one, in fade mode or for a negative linear time difference, and shorter
// when the quotient saturates; set by the single table read port, the shared multiplier
// and the bit-serial divider; a zero difference or negative linear level skips on
// a result waiting in the output register stalls the sequencer; reset sets cursor to 1
`default_nettype none
`include "daily_light_schedule_interpolator_top_defines.svh"
module daily_light_schedule_interpolator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [4:0] point_index, [15:5] point_minutes, [23:16] point_level, [40:24] time_of_day
	input  wire logic [47:0] s_tdata,
	// [1:0] func
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] light_value
	output logic [7:0]       m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import dlsi_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REWIND,
		ST_CHECK,
		ST_RD_PREV,
		ST_RD_NEXT,
		ST_SETUP,
		ST_MUL_A,
		ST_MUL_B,
		ST_SIGN,
		ST_SQ_MAG,
		ST_SQ_TD,
		ST_SCALE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic                fade_q;
	logic [CNT_W-1:0]    count_q;
	point_t              mem_q [MAX_POINTS];
	point_t              rd_q;
	logic [ADDR_W-1:0]   rd_addr;
	logic [IDX_W-1:0]    cursor_q;
	logic [IDX_W-1:0]    nxt_q;
	point_t              prev_q;
	point_t              next_q;
	logic [TOD_W-1:0]    t_q;
	logic [IDX_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    moves_q;
	logic [TD_W-1:0]     td_q;
	logic [TD_W-1:0]     prog_q;
	logic                dneg_q;
	logic [LVL_W-1:0]    dmag_q;
	logic [LVL_W-1:0]    plev_q;
	logic [NUM_W-1:0]    acc_q;
	logic [NUM_W-1:0]    num_q;
	logic [MUL_W-1:0]    mag_q;
	logic [DIV_W-1:0]    dvd_q;
	logic [DIV_W-1:0]    dvs_q;
	logic [LVL_W-1:0]    res_q;
	logic                m_valid_q;
	logic [LVL_W-1:0]    m_data_q;

	logic [1:0]          in_func;
	logic [4:0]          in_index;
	logic [MIN_W-1:0]    in_minutes;
	logic [LVL_W-1:0]    in_level;
	logic [TOD_W-1:0]    in_tod;
	logic                accept;
	logic                cfg_wr;
	logic                idx_ok;
	logic [IDX_W-1:0]    used_cnt;
	logic                out_load;

	logic [IDX_W:0]      c1;
	logic [IDX_W-1:0]    adv_cur;
	logic [IDX_W-1:0]    adv_nxt;
	logic [SEC_W-1:0]    p_sec;
	logic [SEC_W-1:0]    n_sec;
	logic                in_int;
	logic [TD_W-1:0]     td_c;
	logic [TD_W-1:0]     prog_c;
	logic [TD_W-1:0]     td_abs;

	logic signed [MUL_W-1:0]   td_sx;
	logic signed [MUL_W-1:0]   prog_sx;
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [2*MUL_W-1:0] prod;
	logic [NUM_W-1:0]    num_c;
	logic [NUM_W-1:0]    mag_c;

	logic                div_start;
	logic                div_wrap;
	logic [LVL_W-1:0]    div_q;
	div_stat_t           div_st;

	assign in_func = s_tuser;
	assign in_index = s_tdata[4:0];
	assign in_minutes = s_tdata[15:5];
	assign in_level = s_tdata[23:16];
	assign in_tod = s_tdata[40:24];

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign idx_ok = (32'(in_index) >= 1) && (32'(in_index) <= MAX_POINTS);

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q <= 1'b0;
			count_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FADE:  fade_q <= pwdata[0];
				REG_COUNT: count_q <= pwdata[CNT_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FADE:  prdata = {31'd0, fade_q};
			REG_COUNT: prdata = {{(32-CNT_W){1'b0}}, count_q};
			default:   prdata = '0;
		endcase
	end

	assign used_cnt = (32'(count_q) > MAX_POINTS) ? IDX_W'(MAX_POINTS) : IDX_W'(count_q);

	// point table, one write and one registered read port
	always_comb begin
		priority case (state_q)
			ST_CHECK:   rd_addr = ADDR_W'(adv_cur - IDX_W'(1));
			ST_RD_PREV: rd_addr = ADDR_W'(nxt_q - IDX_W'(1));
			default:    rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && in_func == FUNC_WRITE && idx_ok)
			mem_q[ADDR_W'(in_index - 5'd1)] <= '{minutes: in_minutes, level: in_level};
		rd_q <= mem_q[rd_addr];
	end

	// cursor move
	assign c1 = {1'b0, cursor_q} + (IDX_W+1)'(1);

	always_comb begin
		if (c1 < {1'b0, cnt_q}) begin
			adv_cur = IDX_W'(c1);
			adv_nxt = IDX_W'(c1 + (IDX_W+1)'(1));
		end else if (c1 == {1'b0, cnt_q}) begin
			adv_cur = IDX_W'(c1);
			adv_nxt = IDX_W'(1);
		end else if (cursor_q == cnt_q) begin
			adv_cur = IDX_W'(1);
			adv_nxt = IDX_W'(2);
		end else begin
			adv_cur = cursor_q;
			adv_nxt = IDX_W'(1);
		end
	end

	assign p_sec = min_to_sec(prev_q.minutes);
	assign n_sec = min_to_sec(next_q.minutes);

	assign in_int = ((p_sec <= t_q) && (n_sec > t_q)) ||
		((p_sec <= t_q) && (n_sec < p_sec)) ||
		((p_sec > t_q) && (n_sec > t_q) && (p_sec > n_sec));

	// time difference and progress are signed, minutes past a day can make them negative
	assign td_c = (p_sec > n_sec) ?
		TD_W'(n_sec) + TD_W'(DAY_SECONDS) - TD_W'(p_sec) :
		TD_W'(n_sec) - TD_W'(p_sec);
	assign prog_c = (t_q >= p_sec) ?
		TD_W'(t_q) - TD_W'(p_sec) :
		TD_W'(t_q) + TD_W'(DAY_SECONDS) - TD_W'(p_sec);

	assign td_sx = {{(MUL_W-TD_W){td_q[TD_W-1]}}, td_q};
	assign prog_sx = {{(MUL_W-TD_W){prog_q[TD_W-1]}}, prog_q};
	assign td_abs = td_q[TD_W-1] ? (~td_q + TD_W'(1)) : td_q;

	// shared multiplier
	always_comb begin
		priority case (state_q)
			ST_MUL_A: begin
				mul_a = MUL_W'(plev_q);
				mul_b = td_sx;
			end
			ST_MUL_B: begin
				mul_a = prog_sx;
				mul_b = MUL_W'(dmag_q);
			end
			ST_SQ_MAG: begin
				mul_a = mag_q;
				mul_b = mag_q;
			end
			ST_SQ_TD: begin
				mul_a = td_sx;
				mul_b = td_sx;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign num_c = dneg_q ? acc_q - prod[NUM_W-1:0] : acc_q + prod[NUM_W-1:0];
	assign mag_c = num_q[NUM_W-1] ? (~num_q + NUM_W'(1)) : num_q;

	assign div_start = (state_q == ST_DIV_GO);
	// a negative linear divisor needs the wrapped low bits of the full quotient
	assign div_wrap = !fade_q && td_q[TD_W-1];

	dlsi_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.wrap     (div_wrap),
		.dividend (dvd_q),
		.divisor  (dvs_q),
		.quotient (div_q),
		.stat     (div_st)
	);

	assign out_load = (state_q == ST_FINISH) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cursor_q <= IDX_W'(1);
			nxt_q <= IDX_W'(1);
			prev_q <= '0;
			next_q <= '0;
			t_q <= '0;
			cnt_q <= '0;
			moves_q <= '0;
			td_q <= '0;
			prog_q <= '0;
			dneg_q <= 1'b0;
			dmag_q <= '0;
			plev_q <= '0;
			acc_q <= '0;
			num_q <= '0;
			mag_q <= '0;
			dvd_q <= '0;
			dvs_q <= '0;
			res_q <= '0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
				m_data_q <= res_q;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_func)
							FUNC_EVAL: begin
								t_q <= in_tod;
								cnt_q <= used_cnt;
								moves_q <= '0;
								state_q <= (used_cnt > IDX_W'(1)) ? ST_CHECK : ST_SETUP;
							end
							FUNC_REWIND: begin
								cursor_q <= IDX_W'(1);
								state_q <= ST_REWIND;
							end
							default: ;
						endcase
					end
				end
				ST_REWIND: begin
					prev_q <= rd_q;
					next_q <= rd_q;
					state_q <= ST_IDLE;
				end
				ST_CHECK: begin
					if (in_int || moves_q == cnt_q) begin
						state_q <= ST_SETUP;
					end else begin
						cursor_q <= adv_cur;
						nxt_q <= adv_nxt;
						state_q <= ST_RD_PREV;
					end
				end
				ST_RD_PREV: begin
					prev_q <= rd_q;
					state_q <= ST_RD_NEXT;
				end
				ST_RD_NEXT: begin
					next_q <= rd_q;
					moves_q <= moves_q + IDX_W'(1);
					state_q <= ST_CHECK;
				end
				ST_SETUP: begin
					td_q <= td_c;
					prog_q <= prog_c;
					plev_q <= prev_q.level;
					dneg_q <= (next_q.level < prev_q.level);
					dmag_q <= (next_q.level < prev_q.level) ?
						prev_q.level - next_q.level : next_q.level - prev_q.level;
					if (td_c == '0) begin
						res_q <= prev_q.level;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: begin
					acc_q <= prod[NUM_W-1:0];
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					num_q <= num_c;
					state_q <= ST_SIGN;
				end
				ST_SIGN: begin
					mag_q <= mag_c[MUL_W-1:0];
					if (fade_q) begin
						state_q <= ST_SQ_MAG;
					end else if (num_q[NUM_W-1]) begin
						res_q <= '0;
						state_q <= ST_FINISH;
					end else begin
						dvd_q <= DIV_W'(mag_c);
						dvs_q <= DIV_W'(td_abs);
						state_q <= ST_DIV_GO;
					end
				end
				ST_SQ_MAG: begin
					dvd_q <= DIV_W'(prod);
					state_q <= ST_SQ_TD;
				end
				ST_SQ_TD: begin
					dvs_q <= DIV_W'(prod);
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					dvs_q <= (dvs_q << LVL_W) - dvs_q;
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_st.done) begin
						res_q <= div_wrap ? (~div_q + LVL_W'(1)) : div_q;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	`DLSI_ASSERT(a_ready_div_idle, s_tready |-> !div_st.busy, "ready while divider busy")
	`DLSI_ASSERT(a_moves_cap, (state_q == ST_CHECK) |-> (moves_q <= cnt_q), "walk past count")
	`DLSI_ASSERT(a_cursor_range, (cursor_q != '0) && (32'(cursor_q) <= MAX_POINTS), "bad cursor")
	`DLSI_ASSERT_NEXT(a_div_to_finish, div_st.done, state_q == ST_FINISH, "quotient dropped")
endmodule
`default_nettype wire
